@@ rtl/mtb_pkg.sv @@
// shared types and constants for the median threshold bitmap block
// no dependencies; used by every module of the block
package mtb_pkg;

  localparam int BINS       = 256;
  localparam int MAX_PIXELS = 1048576;

  localparam int PIX_W  = 8;
  localparam int BIN_W  = $clog2(BINS);
  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int MED_W  = $clog2(BINS + 1);
  localparam int SUM_W  = CNT_W + BIN_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic REQ_HIST   = 1'b0;
  localparam logic REQ_THRESH = 1'b1;

  localparam logic KIND_MEDIAN = 1'b0;
  localparam logic KIND_BIT    = 1'b1;

  typedef enum logic [1:0] {
    OP_HIST      = 2'd0,
    OP_HIST_LAST = 2'd1,
    OP_THRESH    = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] pixel;
  } cmd_t;

endpackage

@@ rtl/median_threshold_bitmap.sv @@
// top level of the median threshold bitmap block
// depends on mtb_pkg, mtb_front and mtb_back
//
// Two-pass grayscale binarization. Histogram-pass pixels (req_type 0) are
// counted into a 256-bin histogram; the pixel flagged last ends the pass, the
// block finds the median as the number of bins summed until the running sum
// reaches half the pixel count, reports it (kind 0), and clears the
// histogram. Threshold-pass pixels (req_type 1) each give one bit,
// pixel > median (kind 1). A command transfers at a clock edge with start
// high and busy low; it lands in a four-entry queue, so busy rises only when
// that queue is full. Each result shows on kind, median and bit_res for one
// cycle with strobe high and must be taken then, since the block cannot be
// held off. In the execution side, a threshold pixel is compared against the
// stored median, a histogram pixel does a read-modify-write of the histogram
// memory, and the last pixel of a pass adds a bin scan over k bins, where k
// is the number of bins summed (up to 256), one memory read and one add per
// bin. Results come out in command order. The histogram is cleared
// at once through per-bin valid flags, so no clearing pass runs after reset
// or after a scan.
module median_threshold_bitmap (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type,
  input  logic [mtb_pkg::PIX_W-1:0] pixel,
  input  logic                      last,
  output logic                      strobe,
  output logic                      kind,
  output logic [mtb_pkg::MED_W-1:0] median,
  output logic                      bit_res
);

  // queue head between the two halves
  logic          q_valid;
  logic          q_pop;
  mtb_pkg::cmd_t q_cmd;

  // command intake and classification
  mtb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .pixel    (pixel),
    .last     (last),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // histogram update, median scan and result register
  mtb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .strobe  (strobe),
    .kind    (kind),
    .median  (median),
    .bit_res (bit_res)
  );

endmodule

@@ rtl/mtb_front.sv @@
// front end: takes commands, classifies them and holds them in a short queue
// depends on mtb_pkg
module mtb_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type,
  input  logic [mtb_pkg::PIX_W-1:0] pixel,
  input  logic                      last,
  output logic                      q_valid,
  output mtb_pkg::cmd_t             q_cmd,
  input  logic                      q_pop
);

  mtb_pkg::cmd_t                q_mem [mtb_pkg::QDEPTH];
  logic [mtb_pkg::QPTR_W-1:0]   wr_ptr;
  logic [mtb_pkg::QPTR_W-1:0]   rd_ptr;
  logic [mtb_pkg::QPTR_W:0]     count;
  logic                         push;
  logic                         pop;
  mtb_pkg::cmd_t                cmd_in;

  // classify the incoming item
  always_comb begin
    cmd_in.pixel = pixel;
    if (req_type == mtb_pkg::REQ_THRESH) begin
      cmd_in.op = mtb_pkg::OP_THRESH;
    end else if (last) begin
      cmd_in.op = mtb_pkg::OP_HIST_LAST;
    end else begin
      cmd_in.op = mtb_pkg::OP_HIST;
    end
  end

  assign busy    = (count == (mtb_pkg::QPTR_W + 1)'(mtb_pkg::QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign pop     = q_pop && q_valid;
  assign q_cmd   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/mtb_back.sv @@
// back end: histogram memory, bin scan and result register
// depends on mtb_pkg
module mtb_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  mtb_pkg::cmd_t             q_cmd,
  output logic                      q_pop,
  output logic                      strobe,
  output logic                      kind,
  output logic [mtb_pkg::MED_W-1:0] median,
  output logic                      bit_res
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_HIST     = 4'b0010,
    S_SCAN_RD  = 4'b0100,
    S_SCAN_ACC = 4'b1000
  } state_t;

  function automatic logic [mtb_pkg::CNT_W-1:0] sat_inc(input logic [mtb_pkg::CNT_W-1:0] v);
    if (v >= mtb_pkg::CNT_W'(mtb_pkg::MAX_PIXELS)) begin
      return mtb_pkg::CNT_W'(mtb_pkg::MAX_PIXELS);
    end
    return v + 1'b1;
  endfunction

  state_t                      state;
  logic [mtb_pkg::CNT_W-1:0]   hist_mem [mtb_pkg::BINS];
  logic [mtb_pkg::BINS-1:0]    hist_vld;
  logic [mtb_pkg::CNT_W-1:0]   rd_data;
  logic                        rd_vld;
  logic [mtb_pkg::BIN_W-1:0]   rd_addr;
  logic                        wr_en;
  logic [mtb_pkg::CNT_W-1:0]   bin_cnt;
  logic [mtb_pkg::PIX_W-1:0]   cur_pix;
  logic                        cur_last;
  logic                        in_range;
  logic [mtb_pkg::CNT_W-1:0]   pixel_count;
  logic [mtb_pkg::MED_W-1:0]   median_value;
  logic [mtb_pkg::SUM_W-1:0]   sum;
  logic [mtb_pkg::MED_W-1:0]   m;
  logic                        scan_more;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign rd_addr  = (state == S_IDLE) ? q_cmd.pixel[mtb_pkg::BIN_W-1:0]
                                      : m[mtb_pkg::BIN_W-1:0];
  // an entry never written since the last clear reads as zero
  assign bin_cnt  = rd_vld ? rd_data : '0;
  assign in_range = ({1'b0, cur_pix} < (mtb_pkg::PIX_W + 1)'(mtb_pkg::BINS));
  assign wr_en    = (state == S_HIST) && in_range;
  assign scan_more = (sum < mtb_pkg::SUM_W'(pixel_count >> 1))
                  && (m < mtb_pkg::MED_W'(mtb_pkg::BINS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[cur_pix[mtb_pkg::BIN_W-1:0]] <= sat_inc(bin_cnt);
    end
    rd_data <= hist_mem[rd_addr];
    rd_vld  <= hist_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      hist_vld     <= '0;
      pixel_count  <= '0;
      median_value <= '0;
      sum          <= '0;
      m            <= '0;
      cur_last     <= 1'b0;
      strobe       <= 1'b0;
      kind         <= mtb_pkg::KIND_MEDIAN;
      median       <= '0;
      bit_res      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_pix  <= q_cmd.pixel;
            cur_last <= (q_cmd.op == mtb_pkg::OP_HIST_LAST);
            if (q_cmd.op == mtb_pkg::OP_THRESH) begin
              strobe  <= 1'b1;
              kind    <= mtb_pkg::KIND_BIT;
              median  <= '0;
              bit_res <= ({1'b0, q_cmd.pixel} > median_value);
            end else begin
              state <= S_HIST;
            end
          end
        end
        S_HIST: begin
          if (in_range) begin
            hist_vld[cur_pix[mtb_pkg::BIN_W-1:0]] <= 1'b1;
          end
          pixel_count <= sat_inc(pixel_count);
          if (cur_last) begin
            sum   <= '0;
            m     <= '0;
            state <= S_SCAN_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN_RD: begin
          if (scan_more) begin
            state <= S_SCAN_ACC;
          end else begin
            strobe       <= 1'b1;
            kind         <= mtb_pkg::KIND_MEDIAN;
            median       <= m;
            bit_res      <= 1'b0;
            median_value <= m;
            pixel_count  <= '0;
            hist_vld     <= '0;
            state        <= S_IDLE;
          end
        end
        S_SCAN_ACC: begin
          sum   <= sum + mtb_pkg::SUM_W'(bin_cnt);
          m     <= m + 1'b1;
          state <= S_SCAN_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/mtb_checker.sv @@
// port-level checks for the median threshold bitmap block, bound to the top
// depends on mtb_pkg and median_threshold_bitmap
module mtb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      busy,
  input logic                      strobe,
  input logic                      kind,
  input logic [mtb_pkg::MED_W-1:0] median,
  input logic                      bit_res
);

  // no result in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result strobe right after reset");

  // a bitmap bit carries a zero median field
  a_bit_median_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == mtb_pkg::KIND_BIT) |-> (median == '0))
    else $error("bitmap result with nonzero median field");

  // a median report carries a zero bit field and a median no larger than the bin count
  a_median_fields: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == mtb_pkg::KIND_MEDIAN)
      |-> (bit_res == 1'b0 && median <= mtb_pkg::MED_W'(mtb_pkg::BINS)))
    else $error("malformed median report");

  // the queue is empty after reset, so busy is low
  a_not_busy_after_reset: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy right after reset");

endmodule

bind median_threshold_bitmap mtb_checker u_mtb_checker (
  .clk     (clk),
  .rst     (rst),
  .busy    (busy),
  .strobe  (strobe),
  .kind    (kind),
  .median  (median),
  .bit_res (bit_res)
);
